>>> sv/davis_b_strength_reduction_macros.svh
// Assertion macros shared by the strength reduction RTL.
`ifndef DAVIS_B_STRENGTH_REDUCTION_MACROS_SVH
`define DAVIS_B_STRENGTH_REDUCTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsr assertion failed");

`endif

>>> sv/dsr_pkg.sv
// Types, constants and lookup functions for the strength reduction block.
package dsr_pkg;

    localparam int          CordicSteps = 30;
    localparam logic [22:0] ANGLE_MAX   = 23'd5898239;
    localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

    typedef struct packed {
        logic        done;
        logic [30:0] sin_v;
        logic [30:0] cos_v;
    } t_cordic_res;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_res;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quo;
    } t_div_res;

    function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            5'd24:   v = 34'sh00000003F;
            5'd25:   v = 34'sh00000001F;
            5'd26:   v = 34'sh00000000F;
            5'd27:   v = 34'sh000000008;
            5'd28:   v = 34'sh000000004;
            5'd29:   v = 34'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
        logic [30:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({3'b000, ONE_Q30})) begin
            r = ONE_Q30;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

>>> sv/dsr_in_if.sv
// Input channel: material parameters and reduction factor.
interface dsr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] cohesion;
    logic [22:0] friction_deg;
    logic [22:0] dilatancy_deg;
    logic [23:0] reduction_factor;

    modport source (output valid, output cohesion, output friction_deg,
                    output dilatancy_deg, output reduction_factor, input ready);
    modport sink   (input valid, input cohesion, input friction_deg,
                    input dilatancy_deg, input reduction_factor, output ready);
endinterface

>>> sv/dsr_out_if.sv
// Output channel: reduced strength results.
interface dsr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] reduced_cbar;
    logic [30:0] reduced_sin_phi;
    logic        bad_factor;

    modport source (output valid, output reduced_cbar, output reduced_sin_phi,
                    output bad_factor, input ready);
    modport sink   (input valid, input reduced_cbar, input reduced_sin_phi,
                    input bad_factor, output ready);
endinterface

>>> sv/dsr_cordic.sv
// Rotation CORDIC, one micro-rotation per cycle, sine and cosine in Q1.30.
module dsr_cordic
    import dsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_z,
    output t_cordic_res        o_res
);
    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_i;
    logic               r_busy, r_done;
    logic signed [33:0] dx, dy, at;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = atan_lut(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == 5'(CordicSteps - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= i_z;
            r_i <= '0;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_i <= r_i + 5'd1;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.sin_v = clamp_unit(r_y);
    assign o_res.cos_v = clamp_unit(r_x);
endmodule

>>> sv/dsr_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
module dsr_sqrt
    import dsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    output t_sqrt_res   o_res
);
    logic [63:0] r_n, r_res, r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.root = r_res[31:0];
endmodule

>>> sv/dsr_div.sv
// Restoring divider, one quotient bit per cycle, flags a quotient too wide.
module dsr_div
    import dsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [62:0] i_num,
    input  logic [36:0] i_den,
    input  logic [5:0]  i_qbits,
    output t_div_res    o_res
);
    logic [62:0] r_rem;
    logic [69:0] r_ds;
    logic [31:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done, r_ovf;
    logic [69:0] ds0, ds_nx;

    assign ds0   = 70'(i_den) << i_qbits;
    assign ds_nx = r_ds >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (70'(i_num) >= ds0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_ds  <= ds0;
            r_q   <= '0;
            r_cnt <= i_qbits;
            r_ovf <= (70'(i_num) >= ds0);
        end else if (r_busy) begin
            r_ds <= ds_nx;
            if (70'(r_rem) >= ds_nx) begin
                r_rem <= r_rem - ds_nx[62:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_q   <= {r_q[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quo  = r_q;
endmodule

>>> sv/davis_b_strength_reduction.sv
// Davis approach B strength reduction: one item in, reduced 2c.cos(phi) and sin(phi) out.
// One item at a time: ready is high only when idle. The time an item takes is set
// by the bit-serial units: two 30-step CORDIC passes, three normalisations
// (one shift a cycle), three 32-step square roots, seven divisions (six of 31 steps and
// one of 32), and the shared 32x32 multiplier. A zero reduction factor goes straight
// from idle to the output state with the error flag set and zero results.
module davis_b_strength_reduction
    import dsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    dsr_in_if.sink    i_in,
    dsr_out_if.source o_res
);
`include "davis_b_strength_reduction_macros.svh"

    localparam logic [4:0] S_IDLE = 5'd0,  S_ZM  = 5'd1,  S_CS  = 5'd2,  S_CW  = 5'd3,
                           S_VA   = 5'd4,  S_VB  = 5'd5,  S_VC  = 5'd6,  S_VD  = 5'd7,
                           S_NRM  = 5'd8,  S_SQA = 5'd9,  S_SQB = 5'd10, S_SQC = 5'd11,
                           S_SQW  = 5'd12, S_DV1 = 5'd13, S_DW1 = 5'd14, S_DV2 = 5'd15,
                           S_DW2  = 5'd16, S_CM  = 5'd17, S_CD  = 5'd18, S_CDW = 5'd19,
                           S_OUT  = 5'd20;

    logic [4:0]  r_state;
    logic [31:0] r_c0;
    logic [22:0] r_phi, r_psi;
    logic [23:0] r_lam;
    logic        r_sel;
    logic [1:0]  r_vec;
    logic [30:0] r_sp, r_cp, r_ss, r_cs, r_s1, r_c1, r_s2, r_c2, r_w;
    logic [63:0] r_a, r_b, r_t, r_sum, r_prod;
    logic [31:0] r_root;
    logic [31:0] r_cbar;
    logic [30:0] r_sinp;
    logic        r_bad;

    logic [31:0] m_a, m_b;
    logic        cor_start, sq_start, dv_start;
    logic signed [33:0] cor_z;
    logic [45:0] z_full;
    logic [62:0] dv_num;
    logic [36:0] dv_den;
    logic [5:0]  dv_qbits;
    logic [32:0] dv_x;
    logic [30:0] ratio_v;
    t_cordic_res cor_res;
    t_sqrt_res   sq_res;
    t_div_res    dv_res;

    dsr_cordic u_cordic (.i_clk, .i_rst_n, .i_start(cor_start), .i_z(cor_z), .o_res(cor_res));
    dsr_sqrt   u_sqrt   (.i_clk, .i_rst_n, .i_start(sq_start), .i_n(r_sum + r_prod),
                         .o_res(sq_res));
    dsr_div    u_div    (.i_clk, .i_rst_n, .i_start(dv_start), .i_num(dv_num),
                         .i_den(dv_den), .i_qbits(dv_qbits), .o_res(dv_res));

    // shared multiplier operands
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_ZM:  begin m_a = 32'(r_sel ? r_psi : r_phi); m_b = DEG2RAD_Q32; end
            S_VA:  begin
                if (r_vec == 2'd0) begin
                    m_a = 32'(r_cp); m_b = 32'(r_lam);
                end else if (r_vec == 2'd1) begin
                    m_a = 32'(r_cs); m_b = 32'(r_lam);
                end else begin
                    m_a = 32'(r_s1); m_b = 32'(r_s2);
                end
            end
            S_VB:  begin m_a = 32'(r_c2); m_b = 32'(r_s1); end
            S_VC:  begin m_a = 32'(r_c1); m_b = 32'(r_c2); end
            S_SQA: begin m_a = r_a[31:0]; m_b = r_a[31:0]; end
            S_SQB: begin m_a = r_b[31:0]; m_b = r_b[31:0]; end
            S_CM:  begin m_a = r_c0;      m_b = 32'(r_w);  end
            default: ;
        endcase
    end

    assign z_full    = 46'((r_prod + 64'h2_0000) >> 18);
    assign cor_z     = $signed({2'b00, z_full[31:0]});
    assign cor_start = (r_state == S_CS);
    assign sq_start  = (r_state == S_SQC);
    assign dv_start  = (r_state == S_DV1) || (r_state == S_DV2) || (r_state == S_CD);

    always_comb begin
        dv_x     = (r_state == S_DV1) ? ((r_vec == 2'd2) ? r_t[32:0] : r_a[32:0]) : r_b[32:0];
        dv_num   = {dv_x, 30'b0} + 63'(r_root[31:1]);
        dv_den   = 37'(r_root);
        dv_qbits = 6'd31;
        if (r_state == S_CD) begin
            dv_num   = r_prod[62:0];
            dv_den   = {r_lam, 13'b0};
            dv_qbits = 6'd32;
        end
    end

    always_comb begin
        if (r_root == '0) begin
            ratio_v = '0;
        end else if (dv_res.ovf || dv_res.quo > 32'(ONE_Q30)) begin
            ratio_v = ONE_Q30;
        end else begin
            ratio_v = dv_res.quo[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(m_a) * 64'(m_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_in.valid) begin
                    r_state <= (i_in.reduction_factor == '0) ? S_OUT : S_ZM;
                end
                S_ZM:  r_state <= S_CS;
                S_CS:  r_state <= S_CW;
                S_CW:  if (cor_res.done) begin
                    r_state <= r_sel ? S_VA : S_ZM;
                end
                S_VA:  r_state <= S_VB;
                S_VB:  r_state <= S_VC;
                S_VC:  r_state <= S_VD;
                S_VD:  r_state <= S_NRM;
                S_NRM: if (r_a[63:31] == '0 && r_b[63:31] == '0) begin
                    r_state <= S_SQA;
                end
                S_SQA: r_state <= S_SQB;
                S_SQB: r_state <= S_SQC;
                S_SQC: r_state <= S_SQW;
                S_SQW: if (sq_res.done) r_state <= S_DV1;
                S_DV1: r_state <= S_DW1;
                S_DW1: if (dv_res.done) r_state <= S_DV2;
                S_DV2: r_state <= S_DW2;
                S_DW2: if (dv_res.done) begin
                    r_state <= (r_vec == 2'd2) ? S_CM : S_VA;
                end
                S_CM:  r_state <= S_CD;
                S_CD:  r_state <= S_CDW;
                S_CDW: if (dv_res.done) r_state <= S_OUT;
                S_OUT: if (o_res.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (i_in.valid) begin
                r_c0   <= i_in.cohesion;
                r_phi  <= (i_in.friction_deg > ANGLE_MAX) ? ANGLE_MAX : i_in.friction_deg;
                r_psi  <= (i_in.dilatancy_deg > ANGLE_MAX) ? ANGLE_MAX : i_in.dilatancy_deg;
                r_lam  <= i_in.reduction_factor;
                r_sel  <= 1'b0;
                r_bad  <= (i_in.reduction_factor == '0);
                r_cbar <= '0;
                r_sinp <= '0;
            end
            S_CW: if (cor_res.done) begin
                if (r_sel) begin
                    r_ss <= cor_res.sin_v;
                    r_cs <= cor_res.cos_v;
                    r_vec <= 2'd0;
                end else begin
                    r_sp <= cor_res.sin_v;
                    r_cp <= cor_res.cos_v;
                    r_sel <= 1'b1;
                end
            end
            S_VB: begin
                if (r_vec == 2'd2) begin
                    r_a <= 64'h1000_0000_0000_0000 - r_prod;
                end else begin
                    r_a <= r_prod;
                    r_b <= {17'b0, (r_vec == 2'd0) ? r_sp : r_ss, 16'b0};
                end
            end
            S_VC: if (r_vec == 2'd2) r_b <= r_prod;
            S_VD: r_t <= r_prod;
            S_NRM: if (r_a[63:31] != '0 || r_b[63:31] != '0) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_t <= r_t >> 1;
            end
            S_SQB: r_sum <= r_prod;
            S_SQW: if (sq_res.done) r_root <= sq_res.root;
            S_DW1: if (dv_res.done) begin
                if (r_vec == 2'd0) r_c1 <= ratio_v;
                else if (r_vec == 2'd1) r_c2 <= ratio_v;
                else r_w <= ratio_v;
            end
            S_DW2: if (dv_res.done) begin
                if (r_vec == 2'd0) r_s1 <= ratio_v;
                else if (r_vec == 2'd1) r_s2 <= ratio_v;
                else r_sinp <= ratio_v;
                r_vec <= r_vec + 2'd1;
            end
            S_CDW: if (dv_res.done) begin
                r_cbar <= dv_res.ovf ? 32'hFFFF_FFFF : dv_res.quo;
            end
            default: ;
        endcase
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_res.valid           = (r_state == S_OUT);
    assign o_res.reduced_cbar    = r_cbar;
    assign o_res.reduced_sin_phi = r_sinp;
    assign o_res.bad_factor      = r_bad;

    `DSR_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_res.valid && o_res.bad_factor,
        o_res.reduced_cbar == '0 && o_res.reduced_sin_phi == '0)
    `DSR_ASSERT_NOW(a_sin_range, i_clk, i_rst_n, o_res.valid,
        o_res.reduced_sin_phi <= ONE_Q30)
    `DSR_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready)
    `DSR_ASSERT_NOW(a_vec_range, i_clk, i_rst_n, r_state == S_NRM, r_vec != 2'd3)
endmodule
